>>> rtl/lir_pkg.sv
// shared constants and types of the linear interpolation resampler
package lir_pkg;
  localparam int unsigned FIELDS       = 4;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned MAX_UPSAMPLE = 8;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned RATE_W       = 18;
  localparam int unsigned PHASE_W      = 19;
  localparam int unsigned COUNT_W      = 16;

  // configuration register indexes
  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_IN_RATE  = 2'd1;
  localparam logic [1:0] REG_OUT_RATE = 2'd2;
  localparam logic [1:0] REG_LIMIT    = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // one result frame
  typedef struct packed {
    sample_t [FIELDS-1:0]  samples;
    logic                  frame_valid;
    logic                  last_of_block;
    logic [COUNT_W-1:0]    frames_emitted;
  } result_t;
endpackage

>>> rtl/lir_lane.sv
// one channel lane: products, sum and a restoring divide by the output rate
module lir_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lir_pkg::sample_t              a,
  input  lir_pkg::sample_t              b,
  input  logic [lir_pkg::PHASE_W-1:0]   pos,
  input  logic [lir_pkg::RATE_W-1:0]    den,
  output logic                          done,
  output lir_pkg::sample_t              result
);
  localparam int unsigned QW = 17;
  localparam int unsigned MW = 34;
  localparam int unsigned RATE_W_L = lir_pkg::RATE_W;

  logic signed [34:0]   p1;
  logic signed [36:0]   p2;
  logic signed [16:0]   diff;
  logic signed [37:0]   num;
  logic [MW-1:0]        mag;
  logic                 neg;
  logic [RATE_W_L-1:0]  rem;
  logic [QW-1:0]        sh;
  logic [4:0]           step;
  logic [1:0]           phase;
  logic [RATE_W_L:0]    trial;

  assign diff  = 17'(b) - 17'(a);
  assign num   = 38'(p1) + 38'(p2);
  assign trial = {rem, sh[QW-1]};

  // multiply, then sum, then load the divider, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase <= 2'd0;
      step  <= '0;
    end else begin
      unique case (phase)
        2'd0: if (start) begin
          p1    <= 35'($signed(a) * $signed({1'b0, den}));
          p2    <= 37'(diff * $signed({1'b0, pos}));
          phase <= 2'd1;
        end
        2'd1: begin
          neg   <= num[37];
          mag   <= MW'(num[37] ? -num : num);
          phase <= 2'd2;
        end
        2'd2: begin
          rem   <= RATE_W_L'(mag[MW-1:QW]);
          sh    <= mag[QW-1:0];
          step  <= '0;
          phase <= 2'd3;
        end
        default: begin
          if (trial >= {1'b0, den}) begin
            rem <= RATE_W_L'(trial - {1'b0, den});
            sh  <= {sh[QW-2:0], 1'b1};
          end else begin
            rem <= trial[RATE_W_L-1:0];
            sh  <= {sh[QW-2:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == 5'(QW - 1)) begin
            phase <= 2'd0;
            done  <= 1'b1;
          end
        end
      endcase
    end
  end

  // restore the sign, truncation toward zero
  always_comb begin
    result = neg ? -lir_pkg::sample_t'(sh[15:0]) : lir_pkg::sample_t'(sh[15:0]);
  end
endmodule

>>> rtl/linear_interp_resampler_unit.sv
// top level of the linear interpolation resampler: sequencer, lanes and output merge
// Each accepted frame is processed alone: every emitted output position runs the four channel
// lanes side by side through a multiply step, a sum step, a load step and a restoring divide,
// plus sequencing steps for issue, completion and push; a position past the output limit
// skips the lanes. The first frame of a block only becomes the previous frame unless it also
// ends the block. Output back-pressure can stall the push and flush steps. Each interpolation
// pass and the end-of-block repeat pass is bounded by MAX_UPSAMPLE positions. A result waits
// in a pending register and moves to the output register when the next one is ready or the
// frame finishes.
module linear_interp_resampler_unit #(
  parameter int unsigned MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // in_sample_0, in_sample_1, in_sample_2, in_sample_3
  input  logic         s_tlast,   // end_of_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // out_sample_0..3, frames_emitted
  output logic         m_tuser,   // frame_valid
  output logic         m_tlast,   // last_of_block
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [17:0]  cfg_data
);
  localparam int unsigned IW = $clog2(MAX_UPSAMPLE + 1);
  localparam int unsigned NF = lir_pkg::FIELDS;
  localparam int unsigned PW = lir_pkg::PHASE_W;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_WAIT, S_PUSH, S_FLUSH} state_t;

  state_t                          state;
  logic [2:0]                      channel_count;
  logic [lir_pkg::RATE_W-1:0]      input_rate;
  logic [lir_pkg::RATE_W-1:0]      output_rate;
  logic [lir_pkg::COUNT_W-1:0]     output_limit;
  lir_pkg::sample_t [NF-1:0]       prev;
  lir_pkg::sample_t [NF-1:0]       cur;
  logic                            have_prev;
  logic [PW-1:0]                   phase;
  logic [lir_pkg::COUNT_W-1:0]     count;
  logic                            last;
  logic                            interp;
  logic [PW-1:0]                   r;
  logic [IW-1:0]                   iter;
  logic                            lane_start;
  logic [NF-1:0]                   lane_done;
  lir_pkg::sample_t [NF-1:0]       lane_res;
  lir_pkg::sample_t [NF-1:0]       lane_b;
  lir_pkg::result_t                pend;
  logic                            pend_valid;
  lir_pkg::result_t                outr;
  logic                            out_free;
  logic                            pass_end;
  logic                            capped;
  logic [2:0]                      active;
  logic [PW-1:0]                   phase_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign capped    = (iter == IW'(MAX_UPSAMPLE));
  assign pass_end  = (r >= {1'b0, output_rate}) || capped;
  assign phase_next = (r >= {1'b0, output_rate}) ? PW'(r - {1'b0, output_rate}) : '0;

  // clamp of the channel count
  always_comb begin
    if (channel_count == 3'd0) active = 3'd1;
    else if (channel_count > 3'(lir_pkg::MAX_CHANNELS)) active = 3'(lir_pkg::MAX_CHANNELS);
    else active = channel_count;
  end

  // channel lanes
  for (genvar j = 0; j < NF; j++) begin : g_lane
    assign lane_b[j] = interp ? cur[j] : prev[j];
    lir_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (lane_start),
      .a      (prev[j]),
      .b      (lane_b[j]),
      .pos    (r),
      .den    (output_rate),
      .done   (lane_done[j]),
      .result (lane_res[j])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 3'd1;
      input_rate    <= 18'd48000;
      output_rate   <= 18'd48000;
      output_limit  <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lir_pkg::REG_CHANNELS: channel_count <= cfg_data[2:0];
        lir_pkg::REG_IN_RATE:  input_rate    <= cfg_data;
        lir_pkg::REG_OUT_RATE: output_rate   <= cfg_data;
        lir_pkg::REG_LIMIT:    output_limit  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, pending merge and output register
  always_ff @(posedge clk) begin
    lane_start <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      have_prev  <= 1'b0;
      phase      <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      prev       <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          for (int j = 0; j < NF; j++) cur[j] <= s_tdata[16*j +: 16];
          last <= s_tlast;
          iter <= '0;
          if (have_prev) begin
            r      <= phase;
            interp <= 1'b1;
            state  <= S_CHECK;
          end else begin
            for (int j = 0; j < NF; j++) prev[j] <= s_tdata[16*j +: 16];
            have_prev <= 1'b1;
            phase     <= '0;
            if (s_tlast) begin
              r      <= '0;
              interp <= 1'b0;
              state  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (pass_end) begin
            if (interp) begin
              phase     <= phase_next;
              prev      <= cur;
              have_prev <= 1'b1;
              if (last) begin
                interp <= 1'b0;
                r      <= phase_next;
                iter   <= '0;
              end else begin
                state <= S_FLUSH;
              end
            end else begin
              state <= S_FLUSH;
            end
          end else begin
            iter <= iter + IW'(1);
            if (count < output_limit) begin
              count      <= count + 16'd1;
              lane_start <= 1'b1;
              state      <= S_WAIT;
            end else begin
              r <= r + PW'(input_rate);
            end
          end
        end
        S_WAIT: if (&lane_done) state <= S_PUSH;
        S_PUSH: if (!pend_valid || out_free) begin
          if (pend_valid) begin
            outr     <= pend;
            m_tvalid <= 1'b1;
          end
          for (int j = 0; j < NF; j++)
            pend.samples[j] <= (3'(j) < active) ? lane_res[j] : '0;
          pend.frame_valid    <= 1'b1;
          pend.last_of_block  <= 1'b0;
          pend.frames_emitted <= count;
          pend_valid <= 1'b1;
          r          <= r + PW'(input_rate);
          state      <= S_CHECK;
        end
        default: begin
          if (!(pend_valid || last)) begin
            state <= S_IDLE;
          end else if (out_free) begin
            if (pend_valid) begin
              outr               <= pend;
              outr.last_of_block <= last;
            end else begin
              outr.samples        <= '0;
              outr.frame_valid    <= 1'b0;
              outr.last_of_block  <= 1'b1;
              outr.frames_emitted <= count;
            end
            m_tvalid   <= 1'b1;
            pend_valid <= 1'b0;
            if (last) begin
              have_prev <= 1'b0;
              phase     <= '0;
              count     <= '0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tdata = {outr.frames_emitted, outr.samples};
  assign m_tuser = outr.frame_valid;
  assign m_tlast = outr.last_of_block;
endmodule

>>> rtl/lir_checker.sv
// port-level checks of the resampler, bound to the top level
module lir_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped while stalled");

  // an empty marker always closes its block
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("empty marker without last");

  // an empty marker carries no samples
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0)
    else $error("empty marker with samples");
endmodule

bind linear_interp_resampler_unit lir_checker u_lir_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> verif/tb_linear_interp_resampler_unit.sv
// self-checking testbench of the linear interpolation resampler with its own frame predictor
module tb_linear_interp_resampler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM       = 170;

  typedef struct {
    logic signed [15:0] s [4];
    logic               eob;
    logic               has_exp;
    logic signed [15:0] e [4];
    logic               e_valid;
    logic               e_last;
    logic [15:0]        e_count;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] s [4];
    logic               frame_valid;
    logic               last_of_block;
    logic [15:0]        frames_emitted;
  } frame_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;   // out_sample_0..3, frames_emitted
  logic         m_tuser;   // frame_valid
  logic         m_tlast;   // last_of_block
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [17:0]  cfg_data;

  // predictor state
  logic [2:0]         mdl_channels;
  logic [17:0]        mdl_in_rate;
  logic [17:0]        mdl_out_rate;
  logic [15:0]        mdl_limit;
  logic signed [15:0] prev_frame [4];
  logic               have_prev;
  logic [18:0]        phase;
  logic [15:0]        block_count;

  frame_t  expected_frames [$];
  int      errors;
  int      frames_seen;
  int      beats_sent;
  int      blocks_sent;
  int      idle_cycles;
  logic    recv_stall_en;

  linear_interp_resampler_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned active_lanes();
    int unsigned c;
    c = mdl_channels;
    if (c < 1) c = 1;
    if (c > lir_pkg::MAX_CHANNELS) c = lir_pkg::MAX_CHANNELS;
    return c;
  endfunction

  function automatic void push_frame(logic signed [15:0] s [4], logic fv);
    frame_t f;
    for (int j = 0; j < 4; j++) f.s[j] = (fv && j < active_lanes()) ? s[j] : 16'sd0;
    f.frame_valid    = fv;
    f.last_of_block  = 1'b0;
    f.frames_emitted = block_count;
    expected_frames.push_back(f);
  endfunction

  // one source interval of positions; interpolate toward cur or repeat the previous frame
  function automatic longint unsigned run_interval(longint unsigned r,
                                                   logic signed [15:0] cur [4], bit interp,
                                                   ref int made);
    int unsigned iter;
    logic signed [15:0] s [4];
    longint a, b, num;
    iter = 0;
    while (r < mdl_out_rate) begin
      if (iter >= lir_pkg::MAX_UPSAMPLE) begin
        r = mdl_out_rate;
        break;
      end
      iter++;
      if (block_count < mdl_limit) begin
        for (int j = 0; j < 4; j++) begin
          a = prev_frame[j];
          if (interp) begin
            b   = cur[j];
            num = a * longint'(mdl_out_rate) + (b - a) * longint'(r);
            s[j] = 16'(num / longint'(mdl_out_rate));
          end else begin
            s[j] = 16'(a);
          end
        end
        block_count++;
        push_frame(s, 1'b1);
        made++;
      end
      r += mdl_in_rate;
    end
    return r;
  endfunction

  function automatic void predict_frame(logic signed [15:0] cur [4], logic eob);
    longint unsigned r;
    int made;
    frame_t f;
    made = 0;
    if (!have_prev) begin
      r = 0;
    end else begin
      r = run_interval(phase, cur, 1'b1, made);
      r = (r - mdl_out_rate) & 19'h7FFFF;
    end
    prev_frame = cur;
    have_prev  = 1'b1;
    phase      = r[18:0];
    if (eob) begin
      void'(run_interval(phase, cur, 1'b0, made));
      if (made == 0) push_frame(cur, 1'b0);
      f = expected_frames.pop_back();
      f.last_of_block = 1'b1;
      expected_frames.push_back(f);
      have_prev   = 1'b0;
      phase       = '0;
      block_count = '0;
    end
  endfunction

  // one register write, then the channel goes idle
  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      lir_pkg::REG_CHANNELS: mdl_channels = val[2:0];
      lir_pkg::REG_IN_RATE:  mdl_in_rate  = val;
      lir_pkg::REG_OUT_RATE: mdl_out_rate = val;
      lir_pkg::REG_LIMIT:    mdl_limit    = val[15:0];
      default: ;
    endcase
  endtask

  // wait until every expected frame has arrived and the block has gone quiet
  task automatic drain();
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (21 * lir_pkg::MAX_UPSAMPLE * 2 + 20) @(posedge clk);
  endtask

  // valid stays high into the next beat when there is no gap
  task automatic send_beat(logic signed [15:0] s [4], logic eob);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {s[3], s[2], s[1], s[0]};
    s_tlast  <= eob;
    do @(posedge clk); while (!s_tready);
    predict_frame(s, eob);
    beats_sent++;
    if (eob) blocks_sent++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  // random blocks under the current setting; mostly short blocks with a flagged end
  task automatic random_blocks(int n_frames);
    logic signed [15:0] s [4];
    int left;
    left = n_frames;
    while (left > 0) begin
      for (int j = 0; j < 4; j++) s[j] = rand_sample();
      left--;
      send_beat(s, (left == 0) || ($urandom_range(0, 5) == 0));
    end
    s_tvalid <= 1'b0;
  endtask

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_stall_en && $urandom_range(0, 3) == 0) begin
      m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // output checker
  always @(posedge clk) begin
    frame_t f;
    if (!rst && m_tvalid && m_tready) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        $error("unexpected output beat: data %h user %b last %b", m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        f = expected_frames.pop_front();
        for (int j = 0; j < 4; j++) begin
          if (m_tdata[16*j +: 16] !== f.s[j]) begin
            $error("out_sample_%0d: expected %0d actual %0d", j, f.s[j],
                   $signed(m_tdata[16*j +: 16]));
            errors++;
          end
        end
        if (m_tdata[79:64] !== f.frames_emitted) begin
          $error("frames_emitted: expected %0d actual %0d", f.frames_emitted, m_tdata[79:64]);
          errors++;
        end
        if (m_tuser !== f.frame_valid) begin
          $error("frame_valid: expected %b actual %b", f.frame_valid, m_tuser);
          errors++;
        end
        if (m_tlast !== f.last_of_block) begin
          $error("last_of_block: expected %b actual %b", f.last_of_block, m_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
        || !s_tvalid && expected_frames.size() == 0) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // directed table: extremes and special cases
  stim_row_t dir_rows [$];

  function automatic stim_row_t mk(int a, int b, int c, int d, logic eob);
    stim_row_t r;
    r.s[0] = 16'(a); r.s[1] = 16'(b); r.s[2] = 16'(c); r.s[3] = 16'(d);
    r.eob = eob;
    r.has_exp = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t mk_exp(int a, logic eob, int ea, logic ev, int cnt);
    stim_row_t r;
    r = mk(a, 16'h5555, 16'hAAAA, 16'h1234, eob);
    r.has_exp = 1'b1;
    r.e[0] = 16'(ea); r.e[1] = 0; r.e[2] = 0; r.e[3] = 0;
    r.e_valid = ev; r.e_last = 1'b1; r.e_count = 16'(cnt);
    return r;
  endfunction

  task automatic run_directed();
    frame_t f;
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].s, dir_rows[i].eob);
      // typed-in expectation must agree with the predicted last beat of the block
      if (dir_rows[i].has_exp) begin
        f = expected_frames[$];
        if (f.s[0] !== dir_rows[i].e[0] || f.frame_valid !== dir_rows[i].e_valid ||
            f.last_of_block !== dir_rows[i].e_last ||
            f.frames_emitted !== dir_rows[i].e_count) begin
          $error("directed row %0d: table value differs from predicted beat", i);
          errors++;
        end
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    errors = 0; frames_seen = 0; beats_sent = 0; blocks_sent = 0;
    recv_stall_en = 1'b1;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
    cfg_valid = 1'b0; cfg_index = lir_pkg::REG_CHANNELS; cfg_data = '0;
    mdl_channels = 3'd1; mdl_in_rate = 18'd48000; mdl_out_rate = 18'd48000;
    mdl_limit = 16'hFFFF;
    for (int j = 0; j < 4; j++) prev_frame[j] = '0;
    have_prev = 1'b0; phase = '0; block_count = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: 1:1 ratio, one channel, single-frame block repeats itself
    dir_rows.push_back(mk_exp(32767, 1'b1, 32767, 1'b1, 1));
    dir_rows.push_back(mk_exp(-32768, 1'b1, -32768, 1'b1, 1));
    run_directed();
    drain();

    // all four channels, 2x upsampling across extremes
    write_reg(lir_pkg::REG_CHANNELS, 18'd4);
    write_reg(lir_pkg::REG_IN_RATE, 18'd1);
    write_reg(lir_pkg::REG_OUT_RATE, 18'd2);
    dir_rows.delete();
    dir_rows.push_back(mk(-32768, 32767, 0, -1, 1'b0));
    dir_rows.push_back(mk(32767, -32768, -1, 0, 1'b0));
    dir_rows.push_back(mk(1, -1, 32767, -32768, 1'b1));
    run_directed();
    drain();

    // ratio beyond the upsample bound and channel count above range
    write_reg(lir_pkg::REG_CHANNELS, 18'd7);
    write_reg(lir_pkg::REG_IN_RATE, 18'd1);
    write_reg(lir_pkg::REG_OUT_RATE, 18'd192000);
    dir_rows.delete();
    dir_rows.push_back(mk(-32768, 100, -100, 32767, 1'b0));
    dir_rows.push_back(mk(32767, -5, 5, -32768, 1'b1));
    run_directed();
    drain();

    // limit of zero: only empty end markers; channel count zero acts as one
    write_reg(lir_pkg::REG_CHANNELS, 18'd0);
    write_reg(lir_pkg::REG_IN_RATE, 18'd48000);
    write_reg(lir_pkg::REG_OUT_RATE, 18'd48000);
    write_reg(lir_pkg::REG_LIMIT, 18'd0);
    dir_rows.delete();
    dir_rows.push_back(mk(1000, 2000, 3000, 4000, 1'b0));
    dir_rows.push_back(mk_exp(-7, 1'b1, 0, 1'b0, 0));
    run_directed();
    drain();

    // zero output rate and zero input rate
    write_reg(lir_pkg::REG_LIMIT, 18'd65535);
    write_reg(lir_pkg::REG_OUT_RATE, 18'd0);
    dir_rows.delete();
    dir_rows.push_back(mk(5, 6, 7, 8, 1'b0));
    dir_rows.push_back(mk_exp(9, 1'b1, 0, 1'b0, 0));
    run_directed();
    drain();
    write_reg(lir_pkg::REG_IN_RATE, 18'd0);
    write_reg(lir_pkg::REG_OUT_RATE, 18'd44100);
    dir_rows.delete();
    dir_rows.push_back(mk(-1, -2, -3, -4, 1'b0));
    dir_rows.push_back(mk(32767, 32767, 32767, 32767, 1'b1));
    run_directed();
    drain();

    // random phases across several settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin write_reg(lir_pkg::REG_CHANNELS, 18'd2);
                 write_reg(lir_pkg::REG_IN_RATE, 18'd44100);
                 write_reg(lir_pkg::REG_OUT_RATE, 18'd48000); end
        1: begin write_reg(lir_pkg::REG_CHANNELS, 18'd3);
                 write_reg(lir_pkg::REG_IN_RATE, 18'd192000);
                 write_reg(lir_pkg::REG_OUT_RATE, 18'd8000); end
        2: begin write_reg(lir_pkg::REG_CHANNELS, 18'd4);
                 write_reg(lir_pkg::REG_IN_RATE, 18'd24000);
                 write_reg(lir_pkg::REG_OUT_RATE, 18'd192000);
                 write_reg(lir_pkg::REG_LIMIT, 18'd5); end
        3: begin write_reg(lir_pkg::REG_LIMIT, 18'd65535);
                 write_reg(lir_pkg::REG_IN_RATE, 18'd192000);
                 write_reg(lir_pkg::REG_OUT_RATE, 18'd192000); end
        4: begin write_reg(lir_pkg::REG_CHANNELS, 18'd1);
                 write_reg(lir_pkg::REG_IN_RATE, 18'd1);
                 write_reg(lir_pkg::REG_OUT_RATE, 18'd3); end
        default: begin
          write_reg(lir_pkg::REG_CHANNELS, 18'($urandom_range(0, 7)));
          write_reg(lir_pkg::REG_IN_RATE, 18'($urandom_range(1, 192000)));
          write_reg(lir_pkg::REG_OUT_RATE, 18'($urandom_range(1, 192000)));
          write_reg(lir_pkg::REG_LIMIT,
                    18'($urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : 65535));
        end
      endcase
      recv_stall_en = (p != 3);
      random_blocks(N_RANDOM / 8);
      // hold the sender until every expected frame is out
      if (p == 1) while (expected_frames.size() != 0) @(posedge clk);
      drain();
    end

    drain();
    $display("covered %0d input beats in %0d blocks, %0d output beats checked",
             beats_sent, blocks_sent, frames_seen);
    $display("settings swept: channel counts 0..7, rates 0..192000, limits 0..65535");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/lir_pkg.sv
rtl/lir_lane.sv
rtl/linear_interp_resampler_unit.sv
rtl/lir_checker.sv
verif/tb_linear_interp_resampler_unit.sv
